// ----- rtl/nearest_centroid_assigner_top_macros.svh -----
// Assertion macros used by the checker module.
`ifndef NEAREST_CENTROID_ASSIGNER_TOP_MACROS_SVH
`define NEAREST_CENTROID_ASSIGNER_TOP_MACROS_SVH

// Same-cycle implication on the checker clock.
`define NCAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the checker clock.
`define NCAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ncas_pkg.sv -----
// Types, constants and command structs of the nearest-centroid assigner.
package ncas_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 4;
    localparam int MAX_POINTS   = 1024;
    localparam int COORD_BITS   = 16;

    localparam int CL_W     = $clog2(MAX_CLUSTERS);
    localparam int DIM_W    = $clog2(MAX_DIMS);
    localparam int PT_W     = $clog2(MAX_POINTS);
    localparam int KCFG_W   = 5;
    localparam int DCFG_W   = 3;
    localparam int SQ_W     = 2 * COORD_BITS;
    localparam int ACC_W    = SQ_W + DIM_W;
    localparam int ROOT_W   = ACC_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SQCNT_W  = $clog2(ROOT_W);
    localparam int DIST_W   = 17;
    localparam int COST_W   = 27;
    localparam int CNT_W    = 11;
    localparam int REC_W    = 1 + CL_W + DIST_W;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 64;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_POINT = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_CLEAR = 2'd3
    } ncas_func_t;

    localparam logic RES_POINT = 1'b0;
    localparam logic RES_COUNT = 1'b1;

    localparam logic REG_CLUSTERS = 1'b0;
    localparam logic REG_DIMS     = 1'b1;

    typedef struct packed {
        logic              accept;
        logic              cen_wr;
        logic              pb_wr;
        logic              clr_wr;
        logic [PT_W-1:0]   clr_addr;
        logic              issue;
        logic [CL_W-1:0]   iss_c;
        logic [DIM_W-1:0]  iss_d;
        logic              iss_first;
        logic              iss_last;
        logic              iss_final;
        logic              sqrt_load;
        logic              sqrt_step;
        logic              rec_rd;
        logic              old_chk;
        logic              dec_wb;
        logic              inc_rd;
        logic              inc_wb;
        logic              q_rd;
        logic              out_load;
    } ncas_cmd_t;

    typedef struct packed {
        logic search_done;
        logic old_valid;
        logic out_free;
    } ncas_stat_t;

endpackage

// ----- rtl/ncas_datapath.sv -----
// Datapath: centroid, record and count memories, distance pipeline, square root, output register.
module ncas_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ncas_pkg::ncas_cmd_t       cmd,
    output ncas_pkg::ncas_stat_t      stat,
    input  logic [1:0]                in_func,
    input  logic [ncas_pkg::IN_W-1:0] in_data,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [ncas_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tuser
);

    logic [ncas_pkg::PT_W-1:0]       in_pidx;
    logic [ncas_pkg::CL_W-1:0]       in_cidx;
    logic [ncas_pkg::DIM_W-1:0]      in_didx;
    logic [ncas_pkg::COORD_BITS-1:0] in_val;

    assign in_pidx = in_data[9:0];
    assign in_cidx = in_data[13:10];
    assign in_didx = in_data[15:14];
    assign in_val  = in_data[31:16];

    logic [1:0]                 func_reg;
    logic [ncas_pkg::PT_W-1:0]  pidx_reg;
    logic [ncas_pkg::CL_W-1:0]  cidx_reg;

    logic [ncas_pkg::COORD_BITS-1:0] cen_mem [ncas_pkg::MAX_CLUSTERS*ncas_pkg::MAX_DIMS];
    logic [ncas_pkg::COORD_BITS-1:0] pbuf_reg [ncas_pkg::MAX_DIMS];
    logic [ncas_pkg::COORD_BITS-1:0] cq_reg, pb1_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic first1_reg, first2_reg, first3_reg;
    logic last1_reg, last2_reg, last3_reg;
    logic final1_reg, final2_reg, final3_reg;
    logic [ncas_pkg::CL_W-1:0] c1_reg, c2_reg, c3_reg;

    logic signed [ncas_pkg::COORD_BITS:0] diff_s;
    logic [ncas_pkg::COORD_BITS:0]        diff_abs;
    logic [ncas_pkg::COORD_BITS-1:0]      diff2_reg;
    logic [ncas_pkg::SQ_W-1:0]            sq3_reg;
    logic [ncas_pkg::ACC_W-1:0]           acc_reg, sum, best_reg;
    logic [ncas_pkg::CL_W-1:0]            bestc_reg;

    logic [ncas_pkg::ACC_W-1:0]  val_sh_reg;
    logic [ncas_pkg::REM_W-1:0]  rem_reg, r2, trial;
    logic [ncas_pkg::ROOT_W-1:0] root_reg;

    logic [ncas_pkg::REC_W-1:0]  rec_mem [ncas_pkg::MAX_POINTS];
    logic [ncas_pkg::REC_W-1:0]  rec_q_reg;
    logic [ncas_pkg::CL_W-1:0]   old_c;
    logic [ncas_pkg::DIST_W-1:0] old_d;

    logic [ncas_pkg::CNT_W-1:0]  cnt_mem [ncas_pkg::MAX_CLUSTERS];
    logic [ncas_pkg::CNT_W-1:0]  cnt_q_reg, cnt_wdata;
    logic [ncas_pkg::CL_W-1:0]   cnt_waddr, cnt_raddr;
    logic                        cnt_we, cnt_re;

    logic [ncas_pkg::COST_W-1:0] cost_reg;
    logic                        out_valid_reg;
    logic [ncas_pkg::OUT_W-1:0]  out_data_reg;
    logic                        out_user_reg;
    logic                        kind;
    logic [ncas_pkg::CNT_W-1:0]  res_count;
    logic [ncas_pkg::DIST_W-1:0] res_dist;
    logic [ncas_pkg::CL_W-1:0]   res_cl;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= in_func;
            pidx_reg <= in_pidx;
            cidx_reg <= in_cidx;
        end
        if (cmd.pb_wr)
            pbuf_reg[in_didx] <= in_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cen_wr)
            cen_mem[{in_cidx, in_didx}] <= in_val;
        if (cmd.issue)
            cq_reg <= cen_mem[{cmd.iss_c, cmd.iss_d}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign diff_s   = $signed({pb1_reg[ncas_pkg::COORD_BITS-1], pb1_reg})
                    - $signed({cq_reg[ncas_pkg::COORD_BITS-1], cq_reg});
    assign diff_abs = diff_s[ncas_pkg::COORD_BITS] ? 17'(-diff_s) : 17'(diff_s);
    assign sum      = (first3_reg ? '0 : acc_reg) + ncas_pkg::ACC_W'(sq3_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            pb1_reg <= pbuf_reg[cmd.iss_d];
        first1_reg <= cmd.iss_first;
        last1_reg  <= cmd.iss_last;
        final1_reg <= cmd.iss_final;
        c1_reg     <= cmd.iss_c;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        final2_reg <= final1_reg;
        c2_reg     <= c1_reg;
        diff2_reg  <= diff_abs[ncas_pkg::COORD_BITS-1:0];
        first3_reg <= first2_reg;
        last3_reg  <= last2_reg;
        final3_reg <= final2_reg;
        c3_reg     <= c2_reg;
        sq3_reg    <= diff2_reg * diff2_reg;
        if (v3_reg)
        begin
            acc_reg <= sum;
            if (last3_reg && (c3_reg == '0 || sum < best_reg))
            begin
                best_reg  <= sum;
                bestc_reg <= c3_reg;
            end
        end
    end

    assign r2    = {rem_reg[ncas_pkg::REM_W-3:0], val_sh_reg[ncas_pkg::ACC_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            val_sh_reg <= best_reg;
            rem_reg    <= '0;
            root_reg   <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            val_sh_reg <= val_sh_reg << 2;
            if (r2 >= trial)
            begin
                rem_reg  <= r2 - trial;
                root_reg <= {root_reg[ncas_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= r2;
                root_reg <= {root_reg[ncas_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            rec_mem[cmd.clr_addr] <= '0;
        else if (cmd.inc_rd)
            rec_mem[pidx_reg] <= {1'b1, bestc_reg, root_reg};
        if (cmd.rec_rd)
            rec_q_reg <= rec_mem[pidx_reg];
    end

    assign old_c = rec_q_reg[ncas_pkg::REC_W-2 -: ncas_pkg::CL_W];
    assign old_d = rec_q_reg[ncas_pkg::DIST_W-1:0];

    always_comb
    begin
        cnt_we    = cmd.clr_wr | cmd.dec_wb | cmd.inc_wb;
        cnt_re    = cmd.old_chk | cmd.inc_rd | cmd.q_rd;
        cnt_waddr = bestc_reg;
        cnt_wdata = cnt_q_reg + 1'b1;
        cnt_raddr = cidx_reg;
        priority if (cmd.clr_wr)
        begin
            cnt_waddr = cmd.clr_addr[ncas_pkg::CL_W-1:0];
            cnt_wdata = '0;
        end
        else if (cmd.dec_wb)
        begin
            cnt_waddr = old_c;
            cnt_wdata = cnt_q_reg - ncas_pkg::CNT_W'(cnt_q_reg != '0);
        end
        priority if (cmd.old_chk)
            cnt_raddr = old_c;
        else if (cmd.inc_rd)
            cnt_raddr = bestc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_q_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cost_reg <= '0;
        else if (cmd.clr_wr)
            cost_reg <= '0;
        else if (cmd.old_chk && rec_q_reg[ncas_pkg::REC_W-1])
            cost_reg <= cost_reg - ncas_pkg::COST_W'(old_d);
        else if (cmd.inc_rd)
            cost_reg <= cost_reg + ncas_pkg::COST_W'(root_reg);
    end

    assign kind      = (func_reg == ncas_pkg::FUNC_QUERY) ? ncas_pkg::RES_COUNT
                                                          : ncas_pkg::RES_POINT;
    assign res_count = (kind == ncas_pkg::RES_COUNT) ? cnt_q_reg : '0;
    assign res_dist  = (kind == ncas_pkg::RES_COUNT) ? '0 : root_reg;
    assign res_cl    = (kind == ncas_pkg::RES_COUNT) ? cidx_reg : bestc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_user_reg <= kind;
            out_data_reg <= {5'b0, res_count, cost_reg, res_dist, res_cl};
        end
    end

    assign stat.search_done = v3_reg & final3_reg;
    assign stat.old_valid   = rec_q_reg[ncas_pkg::REC_W-1];
    assign stat.out_free    = ~out_valid_reg | m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- rtl/ncas_ctrl.sv -----
// Controller: sequences loads, clears, count queries, the centroid search, the square root and record updates.
module ncas_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_func,
    input  logic [ncas_pkg::DIM_W-1:0]    in_didx,
    input  logic [ncas_pkg::KCFG_W-1:0]   k_use,
    input  logic [ncas_pkg::DCFG_W-1:0]   dims_use,
    input  ncas_pkg::ncas_stat_t          stat,
    output ncas_pkg::ncas_cmd_t           cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIST,
        ST_DRAIN,
        ST_SQ_LOAD,
        ST_SQRT,
        ST_REC_RD,
        ST_REC_OLD,
        ST_DEC_WB,
        ST_INC_RD,
        ST_INC_WB,
        ST_Q_RD,
        ST_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [ncas_pkg::CL_W-1:0]      c_reg, c_next;
    logic [ncas_pkg::DIM_W-1:0]     d_reg, d_next;
    logic [ncas_pkg::SQCNT_W-1:0]   sq_reg, sq_next;
    logic [ncas_pkg::PT_W-1:0]      clr_reg, clr_next;
    logic                           accept, last_d, last_c, pt_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;
    assign last_d   = ncas_pkg::DCFG_W'(d_reg) == dims_use - 1'b1;
    assign last_c   = ncas_pkg::KCFG_W'(c_reg) == k_use - 1'b1;
    assign pt_last  = ncas_pkg::DCFG_W'(in_didx) == dims_use - 1'b1;

    always_comb
    begin
        cmd          = '0;
        cmd.clr_addr = clr_reg;
        cmd.iss_c    = c_reg;
        cmd.iss_d    = d_reg;
        state_next   = state_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        clr_next     = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == ncas_pkg::PT_W'(ncas_pkg::MAX_POINTS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    unique case (ncas_pkg::ncas_func_t'(in_func))
                        ncas_pkg::FUNC_LOAD:
                            cmd.cen_wr = 1'b1;
                        ncas_pkg::FUNC_POINT:
                        begin
                            cmd.pb_wr = 1'b1;
                            if (pt_last)
                            begin
                                c_next     = '0;
                                d_next     = '0;
                                state_next = ST_DIST;
                            end
                        end
                        ncas_pkg::FUNC_QUERY:
                            state_next = ST_Q_RD;
                        ncas_pkg::FUNC_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIST:
            begin
                cmd.issue     = 1'b1;
                cmd.iss_first = (d_reg == '0);
                cmd.iss_last  = last_d;
                cmd.iss_final = last_d & last_c;
                if (last_d)
                begin
                    d_next = '0;
                    c_next = c_reg + 1'b1;
                    if (last_c)
                        state_next = ST_DRAIN;
                end
                else
                    d_next = d_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (stat.search_done)
                    state_next = ST_SQ_LOAD;
            end
            ST_SQ_LOAD:
            begin
                cmd.sqrt_load = 1'b1;
                sq_next       = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                sq_next       = sq_reg + 1'b1;
                if (sq_reg == ncas_pkg::SQCNT_W'(ncas_pkg::ROOT_W - 1))
                    state_next = ST_REC_RD;
            end
            ST_REC_RD:
            begin
                cmd.rec_rd = 1'b1;
                state_next = ST_REC_OLD;
            end
            ST_REC_OLD:
            begin
                cmd.old_chk = 1'b1;
                state_next  = stat.old_valid ? ST_DEC_WB : ST_INC_RD;
            end
            ST_DEC_WB:
            begin
                cmd.dec_wb = 1'b1;
                state_next = ST_INC_RD;
            end
            ST_INC_RD:
            begin
                cmd.inc_rd = 1'b1;
                state_next = ST_INC_WB;
            end
            ST_INC_WB:
            begin
                cmd.inc_wb = 1'b1;
                state_next = ST_OUT;
            end
            ST_Q_RD:
            begin
                cmd.q_rd   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            c_reg     <= '0;
            d_reg     <= '0;
            sq_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            sq_reg    <= sq_next;
            clr_reg   <= clr_next;
        end
    end

endmodule

// ----- rtl/nearest_centroid_assigner_top.sv -----
// Top level of the nearest-centroid assigner: configuration port, controller and datapath.
//
// Input stream s_axis: tuser carries the function (load centroid coordinate, point
// coordinate, count query, clear). Output stream m_axis: tuser carries the result kind
// (point assignment or cluster count). Registers clusters_in_use (0x0) and dims_in_use
// (0x4) are written through the APB port; the user is to write them only while the block
// is idle, which the block itself does not enforce. Centroid loads and non-final point
// coordinates give no result. A final point coordinate walks clusters*dims centroid
// coordinates, one per cycle through the centroid memory read port, then the distance
// pipeline drains, a load step and a 17-step iterative square root run, and the states
// REC_RD, REC_OLD, DEC_WB (skipped for a point with no record), INC_RD, INC_WB and OUT
// update the point record, the cluster counts and the total cost and load the output.
// A count query reads one cluster count and loads it into the output register. Clear
// sweeps the point record memory and the counts and zeroes the total cost.
// After reset the block sweeps its 1024-entry point record memory and the counts,
// one entry a cycle, before accepting the first transaction.
// One item is worked on at a time; a finished result waits in the output register
// while the next transaction is taken, and a stalled receiver holds the block only
// when a second result is ready.
module nearest_centroid_assigner_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // point_index[9:0], cluster_index[13:10], coord_index[15:14], coord_value[31:16]
    input  logic [31:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // assigned_cluster[3:0], distance[20:4], total_cost[47:21], member_count[58:48]
    output logic [63:0] m_axis_tdata,
    // result_kind[0]
    output logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ncas_pkg::KCFG_W-1:0] clusters_reg;
    logic [ncas_pkg::DCFG_W-1:0] dims_reg;
    logic [ncas_pkg::KCFG_W-1:0] k_use;
    logic [ncas_pkg::DCFG_W-1:0] dims_use;
    logic                        cfg_wr;
    ncas_pkg::ncas_cmd_t         cmd;
    ncas_pkg::ncas_stat_t        stat;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clusters_reg <= ncas_pkg::KCFG_W'(ncas_pkg::MAX_CLUSTERS);
            dims_reg     <= ncas_pkg::DCFG_W'(ncas_pkg::MAX_DIMS);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ncas_pkg::REG_CLUSTERS)
                clusters_reg <= pwdata[ncas_pkg::KCFG_W-1:0];
            else
                dims_reg <= pwdata[ncas_pkg::DCFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ncas_pkg::REG_DIMS) ? 32'(dims_reg) : 32'(clusters_reg);

    always_comb
    begin
        priority if (clusters_reg == '0)
            k_use = ncas_pkg::KCFG_W'(1);
        else if (clusters_reg > ncas_pkg::KCFG_W'(ncas_pkg::MAX_CLUSTERS))
            k_use = ncas_pkg::KCFG_W'(ncas_pkg::MAX_CLUSTERS);
        else
            k_use = clusters_reg;
        priority if (dims_reg == '0)
            dims_use = ncas_pkg::DCFG_W'(1);
        else if (dims_reg > ncas_pkg::DCFG_W'(ncas_pkg::MAX_DIMS))
            dims_use = ncas_pkg::DCFG_W'(ncas_pkg::MAX_DIMS);
        else
            dims_use = dims_reg;
    end

    ncas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_func  (s_axis_tuser),
        .in_didx  (s_axis_tdata[15:14]),
        .k_use    (k_use),
        .dims_use (dims_use),
        .stat     (stat),
        .cmd      (cmd)
    );

    ncas_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_func       (s_axis_tuser),
        .in_data       (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/ncas_checker.sv -----
// Port-level checker of the nearest-centroid assigner and its bind.
`include "nearest_centroid_assigner_top_macros.svh"

module ncas_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `NCAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `NCAS_ASSERT_NOW(a_point_no_count, m_axis_tvalid && (m_axis_tuser == ncas_pkg::RES_POINT), m_axis_tdata[58:48] == 11'd0, "assignment result carries a count")
    `NCAS_ASSERT_NOW(a_count_no_dist, m_axis_tvalid && (m_axis_tuser == ncas_pkg::RES_COUNT), m_axis_tdata[20:4] == 17'd0, "count answer carries a distance")

endmodule

bind nearest_centroid_assigner_top ncas_checker u_ncas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
